// File: rtl/dfoc_pkg.sv
package dfoc_pkg;

  // Fixed point format
  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 31;
  localparam int DATA_W    = 32;

  // Register map, index = paddr / 4
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = IDX_W + 2;

  localparam logic [IDX_W-1:0] REG_LIN_C = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIN_P = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIN_S = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROT_C = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROT_P = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROT_S = 3'd5;
  localparam logic [IDX_W-1:0] REG_MASS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DT    = 3'd7;

  localparam logic [REG_W-1:0] ONE_FX    = REG_W'(64'd1 << FRAC_BITS);
  localparam logic [REG_W-1:0] DT_RESET  = REG_W'(655);

  // Result action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ZERO  = 2'd1;
  localparam logic [1:0] ACT_APPLY = 2'd2;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Unit depths: input register plus one stage per result bit
  localparam int ISQRT_LAT = DATA_W + 1;
  localparam int DIV_LAT   = DATA_W + 1;

  typedef struct packed {
    logic                   rot;
    logic                   moving;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] am;
  } item_t;

  typedef struct packed {
    logic [REG_W-1:0] lin_c;
    logic [REG_W-1:0] lin_p;
    logic [REG_W-1:0] lin_s;
    logic [REG_W-1:0] rot_c;
    logic [REG_W-1:0] rot_p;
    logic [REG_W-1:0] rot_s;
    logic [REG_W-1:0] mass;
    logic [REG_W-1:0] dt;
  } coef_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/dfoc_front.sv
module dfoc_front import dfoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type,
  input  logic                     in_motion,
  input  logic signed [DATA_W-1:0] comp_x,
  input  logic signed [DATA_W-1:0] comp_y,
  input  logic signed [DATA_W-1:0] comp_z,
  input  q_stat_t                  q_stat,
  output logic                     push,
  output item_t                    push_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic  accept;
  logic [2:0][DATA_W-1:0] raw;

  assign raw    = {comp_z, comp_y, comp_x};
  assign push   = valid_r && !q_stat.full;
  assign busy   = valid_r && q_stat.full;
  assign accept = start && !busy;

  // Split each component into sign and magnitude
  always_comb begin
    item_nxt.rot    = req_type;
    item_nxt.moving = in_motion;
    for (int i = 0; i < 3; i++) begin
      item_nxt.neg[i] = raw[i][DATA_W-1];
      item_nxt.am[i]  = raw[i][DATA_W-1] ? (~raw[i] + DATA_W'(1)) : raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_item = item_r;

endmodule

// File: rtl/dfoc_queue.sv
module dfoc_queue import dfoc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output logic    pop_valid,
  output item_t   pop_item,
  output q_stat_t q_stat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_valid    = !q_stat.empty;
  assign pop_item     = mem_r[rd_ptr_r];
  assign do_pop       = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/dfoc_isqrt.sv
module dfoc_isqrt import dfoc_pkg::*; (
  input  logic                  clk,
  input  logic [2*DATA_W-1:0]   rad,
  output logic [DATA_W-1:0]     root
);

  localparam int REM_W = DATA_W + 2;

  logic [2*DATA_W-1:0] v_r     [DATA_W+1];
  logic [REM_W-1:0]    rem_r   [DATA_W+1];
  logic [DATA_W-1:0]   root_r  [DATA_W+1];
  logic [2*DATA_W-1:0] v_nxt   [DATA_W];
  logic [REM_W-1:0]    rem_nxt [DATA_W];
  logic [DATA_W-1:0]   root_nxt[DATA_W];

  // One result bit per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    for (int k = 0; k < DATA_W; k++) begin
      shifted    = {rem_r[k], v_r[k][2*DATA_W-1 -: 2]};
      trial      = {2'b00, root_r[k], 2'b01};
      v_nxt[k]   = {v_r[k][2*DATA_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt[k]  = REM_W'(shifted - trial);
        root_nxt[k] = {root_r[k][DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = shifted[REM_W-1:0];
        root_nxt[k] = {root_r[k][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r[0]    <= rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    for (int k = 0; k < DATA_W; k++) begin
      v_r[k+1]    <= v_nxt[k];
      rem_r[k+1]  <= rem_nxt[k];
      root_r[k+1] <= root_nxt[k];
    end
  end

  assign root = root_r[DATA_W];

endmodule

// File: rtl/dfoc_div.sv
module dfoc_div import dfoc_pkg::*; (
  input  logic                clk,
  input  logic [2*DATA_W-1:0] num,
  input  logic [DATA_W-1:0]   den,
  output logic [DATA_W-1:0]   quo
);

  // Quotient must fit DATA_W bits: upper half of num below den

  logic [DATA_W-1:0] rem_r  [DATA_W+1];
  logic [DATA_W-1:0] lo_r   [DATA_W+1];
  logic [DATA_W-1:0] q_r    [DATA_W+1];
  logic [DATA_W-1:0] den_r  [DATA_W+1];
  logic [DATA_W-1:0] rem_nxt[DATA_W];
  logic [DATA_W-1:0] q_nxt  [DATA_W];

  always_comb begin
    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    for (int k = 0; k < DATA_W; k++) begin
      shifted = {rem_r[k], lo_r[k][DATA_W-1]};
      diff    = shifted - {1'b0, den_r[k]};
      if (shifted >= {1'b0, den_r[k]}) begin
        rem_nxt[k] = diff[DATA_W-1:0];
        q_nxt[k]   = {q_r[k][DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = shifted[DATA_W-1:0];
        q_nxt[k]   = {q_r[k][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num[2*DATA_W-1:DATA_W];
    lo_r[0]  <= num[DATA_W-1:0];
    q_r[0]   <= '0;
    den_r[0] <= den;
    for (int k = 0; k < DATA_W; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      lo_r[k+1]  <= {lo_r[k][DATA_W-2:0], 1'b0};
      q_r[k+1]   <= q_nxt[k];
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = q_r[DATA_W];

endmodule

// File: rtl/dfoc_back.sv
module dfoc_back import dfoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  input  coef_t                    coef,
  output logic                     out_valid,
  output logic [1:0]               out_action,
  output logic signed [DATA_W-1:0] out_force_x,
  output logic signed [DATA_W-1:0] out_force_y,
  output logic signed [DATA_W-1:0] out_force_z,
  output logic                     out_clipped
);

  localparam int W2 = 2 * DATA_W;
  localparam int PW = DATA_W + REG_W;

  typedef struct packed {
    logic                   valid;
    logic                   moving;
    logic                   rot;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] am;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [DATA_W-1:0] mag;
    logic [PW-1:0]     mm;
    logic [DATA_W-1:0] d;
    logic              clip;
  } drag_t;

  typedef struct packed {
    logic                   valid;
    logic                   moving;
    logic                   magz;
    logic                   test;
    logic                   clip;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] am;
    logic [DATA_W-1:0]      d;
    logic [DATA_W-1:0]      mag;
  } clamp_t;

  typedef struct packed {
    logic       valid;
    logic       moving;
    logic       magz;
    logic       clip;
    logic [2:0] neg;
  } fin_t;

  assign q_pop = q_valid;

  // Squares and sum of squares
  tag_t            tag_b1_r, tag_b2_r, tag_nxt;
  logic [W2-1:0]   sqa_r [3];
  logic [W2-1:0]   sumsq_r;
  logic [DATA_W-1:0] root;
  tag_t            tag_dl_r [ISQRT_LAT];
  tag_t            tag_sq;

  always_comb begin
    tag_nxt.valid  = q_valid;
    tag_nxt.moving = q_item.moving;
    tag_nxt.rot    = q_item.rot;
    tag_nxt.neg    = q_item.neg;
    tag_nxt.am     = q_item.am;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b1_r <= '0;
      tag_b2_r <= '0;
      for (int k = 0; k < ISQRT_LAT; k++) begin
        tag_dl_r[k] <= '0;
      end
    end else begin
      tag_b1_r    <= tag_nxt;
      tag_b2_r    <= tag_b1_r;
      tag_dl_r[0] <= tag_b2_r;
      for (int k = 1; k < ISQRT_LAT; k++) begin
        tag_dl_r[k] <= tag_dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sqa_r[i] <= {{DATA_W{1'b0}}, q_item.am[i]} * {{DATA_W{1'b0}}, q_item.am[i]};
    end
    sumsq_r <= sqa_r[0] + sqa_r[1] + sqa_r[2];
  end

  dfoc_isqrt u_isqrt (
    .clk  (clk),
    .rad  (sumsq_r),
    .root (root)
  );

  assign tag_sq = tag_dl_r[ISQRT_LAT-1];

  // Drag magnitude
  drag_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [PW-1:0]     praw_r;
  logic [W2-1:0]     msq_r;
  logic [W2-1:0]     sq_r;
  logic [PW-1:0]     ph_r, pl_r;
  logic [DATA_W-1:0] t_r;
  logic [PW-1:0]     ddt_r;
  logic [REG_W-1:0]  c_sel, p_sel, s_sel, m_sel;
  logic [W2-1:0]     sum1;
  logic [W2-1:0]     pterm;
  logic [3*DATA_W-1:0] full;
  logic [DATA_W:0]   sum2;
  logic              tclip;

  assign c_sel = tag_sq.rot ? coef.rot_c : coef.lin_c;
  assign p_sel = tag_sq.rot ? coef.rot_p : coef.lin_p;
  assign m_sel = tag_sq.rot ? ONE_FX     : coef.mass;
  assign s_sel = c2_r.tag.rot ? coef.rot_s : coef.lin_s;

  assign pterm = W2'({1'b0, praw_r} >> FRAC_BITS);
  assign sum1  = pterm + W2'(c1_r.d);
  assign full  = (3*DATA_W)'({ph_r, {DATA_W{1'b0}}}) + (3*DATA_W)'(pl_r);
  assign tclip = |full[3*DATA_W-1:DATA_W+FRAC_BITS];
  assign sum2  = {1'b0, c4_r.d} + {1'b0, t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else begin
      c1_r.tag  <= tag_sq;
      c1_r.mag  <= root;
      c1_r.mm   <= {{REG_W{1'b0}}, root} * {{DATA_W{1'b0}}, m_sel};
      c1_r.d    <= DATA_W'(c_sel);
      c1_r.clip <= 1'b0;

      // Add proportional term, saturate
      c2_r.tag  <= c1_r.tag;
      c2_r.mag  <= c1_r.mag;
      c2_r.mm   <= c1_r.mm;
      c2_r.d    <= (|sum1[W2-1:DATA_W]) ? '1 : sum1[DATA_W-1:0];
      c2_r.clip <= |sum1[W2-1:DATA_W];

      c3_r <= c2_r;

      // Quadratic term, saturate
      c4_r.tag  <= c3_r.tag;
      c4_r.mag  <= c3_r.mag;
      c4_r.mm   <= c3_r.mm;
      c4_r.d    <= c3_r.d;
      c4_r.clip <= c3_r.clip | tclip;

      c5_r.tag  <= c4_r.tag;
      c5_r.mag  <= c4_r.mag;
      c5_r.mm   <= c4_r.mm;
      c5_r.d    <= sum2[DATA_W] ? '1 : sum2[DATA_W-1:0];
      c5_r.clip <= c4_r.clip | sum2[DATA_W];

      c6_r <= c5_r;
    end
  end

  always_ff @(posedge clk) begin
    praw_r <= {{REG_W{1'b0}}, root} * {{DATA_W{1'b0}}, p_sel};
    msq_r  <= {{DATA_W{1'b0}}, root} * {{DATA_W{1'b0}}, root};
    sq_r   <= msq_r >> FRAC_BITS;
    ph_r   <= {{REG_W{1'b0}}, sq_r[W2-1:DATA_W]} * {{DATA_W{1'b0}}, s_sel};
    pl_r   <= {{REG_W{1'b0}}, sq_r[DATA_W-1:0]} * {{DATA_W{1'b0}}, s_sel};
    t_r    <= tclip ? '1 : full[DATA_W+FRAC_BITS-1:FRAC_BITS];
    ddt_r  <= {{REG_W{1'b0}}, c5_r.d} * {{DATA_W{1'b0}}, coef.dt};
  end

  // Overshoot clamp: D = |v|*m / dt where D*dt exceeds |v|*m
  clamp_t            cl_nxt, cl_e1_r;
  clamp_t            cl_dl_r [DIV_LAT];
  clamp_t            cl_last;
  logic [DATA_W-1:0] clamp_q;

  always_comb begin
    cl_nxt.valid  = c6_r.tag.valid;
    cl_nxt.moving = c6_r.tag.moving;
    cl_nxt.magz   = (c6_r.mag == '0);
    cl_nxt.test   = (coef.dt != '0) && (ddt_r > c6_r.mm);
    cl_nxt.clip   = c6_r.clip;
    cl_nxt.neg    = c6_r.tag.neg;
    cl_nxt.am     = c6_r.tag.am;
    cl_nxt.d      = c6_r.d;
    cl_nxt.mag    = c6_r.mag;
  end

  dfoc_div u_div_clamp (
    .clk (clk),
    .num ({{(W2-PW){1'b0}}, c6_r.mm}),
    .den ({{(DATA_W-REG_W){1'b0}}, coef.dt}),
    .quo (clamp_q)
  );

  assign cl_last = cl_dl_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_e1_r <= '0;
      for (int k = 0; k < DIV_LAT; k++) begin
        cl_dl_r[k] <= '0;
      end
    end else begin
      cl_dl_r[0] <= cl_nxt;
      for (int k = 1; k < DIV_LAT; k++) begin
        cl_dl_r[k] <= cl_dl_r[k-1];
      end
      cl_e1_r.valid  <= cl_last.valid;
      cl_e1_r.moving <= cl_last.moving;
      cl_e1_r.magz   <= cl_last.magz;
      cl_e1_r.test   <= cl_last.test;
      cl_e1_r.clip   <= cl_last.clip;
      cl_e1_r.neg    <= cl_last.neg;
      cl_e1_r.am     <= cl_last.am;
      cl_e1_r.d      <= cl_last.test ? clamp_q : cl_last.d;
      cl_e1_r.mag    <= cl_last.mag;
    end
  end

  // Per-component share of D: D*|c| / |v|
  fin_t              fin_e2_r;
  fin_t              fin_dl_r [DIV_LAT];
  fin_t              fin;
  logic [W2-1:0]     prod_r [3];
  logic [DATA_W-1:0] mag_e2_r;
  logic [2:0][DATA_W-1:0] quo;
  logic [2:0][DATA_W-1:0] force_nxt;
  logic              clip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_e2_r <= '0;
      for (int k = 0; k < DIV_LAT; k++) begin
        fin_dl_r[k] <= '0;
      end
    end else begin
      fin_e2_r.valid  <= cl_e1_r.valid;
      fin_e2_r.moving <= cl_e1_r.moving;
      fin_e2_r.magz   <= cl_e1_r.magz;
      fin_e2_r.clip   <= cl_e1_r.clip;
      fin_e2_r.neg    <= cl_e1_r.neg;
      fin_dl_r[0]     <= fin_e2_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        fin_dl_r[k] <= fin_dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_e2_r <= cl_e1_r.mag;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= {{DATA_W{1'b0}}, cl_e1_r.d} * {{DATA_W{1'b0}}, cl_e1_r.am[i]};
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_comp
    dfoc_div u_div_comp (
      .clk (clk),
      .num (prod_r[g]),
      .den (mag_e2_r),
      .quo (quo[g])
    );
  end

  assign fin = fin_dl_r[DIV_LAT-1];

  // Saturate and oppose the direction
  always_comb begin
    clip_nxt = fin.clip;
    for (int i = 0; i < 3; i++) begin
      if (fin.neg[i]) begin
        if (quo[i][DATA_W-1]) begin
          clip_nxt     = 1'b1;
          force_nxt[i] = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          force_nxt[i] = quo[i];
        end
      end else begin
        if (quo[i] > {1'b1, {(DATA_W-1){1'b0}}}) begin
          clip_nxt     = 1'b1;
          force_nxt[i] = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          force_nxt[i] = ~quo[i] + DATA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!fin.moving) begin
      out_action  <= ACT_NONE;
      out_force_x <= '0;
      out_force_y <= '0;
      out_force_z <= '0;
      out_clipped <= 1'b0;
    end else if (fin.magz) begin
      out_action  <= ACT_ZERO;
      out_force_x <= '0;
      out_force_y <= '0;
      out_force_z <= '0;
      out_clipped <= 1'b0;
    end else begin
      out_action  <= ACT_APPLY;
      out_force_x <= force_nxt[0];
      out_force_y <= force_nxt[1];
      out_force_z <= force_nxt[2];
      out_clipped <= clip_nxt;
    end
  end

endmodule

// File: rtl/drag_force_with_overshoot_clamp.sv
// Quadratic drag force with overshoot clamp. Give one vector (linear velocity
// or angular rotation) per cycle: an item is taken at a clock edge with start
// high and busy low, and its result shows up on the out_ ports for exactly one
// cycle, marked by out_valid, after passing through the queue write, the
// squares and their sum, the square root, the drag terms, the clamp divider,
// the choice of D and the products, the component dividers and the output
// register. The pipeline takes one item per cycle, so busy never rises while
// results flow out; the receiver must take every result as it is shown. The
// user must write registers over the APB port only while no item is in flight;
// the block does not enforce this. Their values feed the pipeline directly.

module drag_force_with_overshoot_clamp import dfoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,

  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,

  // Input items
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic                     in_in_motion,
  input  logic signed [DATA_W-1:0] in_comp_x,
  input  logic signed [DATA_W-1:0] in_comp_y,
  input  logic signed [DATA_W-1:0] in_comp_z,

  // Results
  output logic                     out_valid,
  output logic [1:0]               out_action,
  output logic signed [DATA_W-1:0] out_force_x,
  output logic signed [DATA_W-1:0] out_force_y,
  output logic signed [DATA_W-1:0] out_force_z,
  output logic                     out_clipped
);

  coef_t            coef_r;
  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_val = pwdata[REG_W-1:0];

  // Register file: keep the low 31 bits of each write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.lin_c <= '0;
      coef_r.lin_p <= '0;
      coef_r.lin_s <= '0;
      coef_r.rot_c <= '0;
      coef_r.rot_p <= '0;
      coef_r.rot_s <= '0;
      coef_r.mass  <= ONE_FX;
      coef_r.dt    <= DT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LIN_C: coef_r.lin_c <= cfg_val;
        REG_LIN_P: coef_r.lin_p <= cfg_val;
        REG_LIN_S: coef_r.lin_s <= cfg_val;
        REG_ROT_C: coef_r.rot_c <= cfg_val;
        REG_ROT_P: coef_r.rot_p <= cfg_val;
        REG_ROT_S: coef_r.rot_s <= cfg_val;
        REG_MASS:  coef_r.mass  <= cfg_val;
        REG_DT:    coef_r.dt    <= cfg_val;
        default:   coef_r.dt    <= coef_r.dt;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (cfg_idx)
      REG_LIN_C: prdata = {1'b0, coef_r.lin_c};
      REG_LIN_P: prdata = {1'b0, coef_r.lin_p};
      REG_LIN_S: prdata = {1'b0, coef_r.lin_s};
      REG_ROT_C: prdata = {1'b0, coef_r.rot_c};
      REG_ROT_P: prdata = {1'b0, coef_r.rot_p};
      REG_ROT_S: prdata = {1'b0, coef_r.rot_s};
      REG_MASS:  prdata = {1'b0, coef_r.mass};
      REG_DT:    prdata = {1'b0, coef_r.dt};
      default:   prdata = '0;
    endcase
  end

  // Front: take the item, split sign and magnitude
  q_stat_t q_stat;
  logic    push;
  item_t   push_item;
  logic    pop;
  logic    pop_valid;
  item_t   pop_item;

  dfoc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (in_req_type),
    .in_motion (in_in_motion),
    .comp_x    (in_comp_x),
    .comp_y    (in_comp_y),
    .comp_z    (in_comp_z),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue decouples front from the arithmetic pipeline
  dfoc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back: magnitude, drag, clamp, per-component force
  dfoc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (pop_valid),
    .q_item      (pop_item),
    .q_pop       (pop),
    .coef        (coef_r),
    .out_valid   (out_valid),
    .out_action  (out_action),
    .out_force_x (out_force_x),
    .out_force_y (out_force_y),
    .out_force_z (out_force_z),
    .out_clipped (out_clipped)
  );

endmodule
